>>> src/lbp_pkg.sv
// lbp_pkg: sizes, codes, command/status structs and helpers of the lru buffer pool
// no dependencies; imported by every other file of the block
package lbp_pkg;

  localparam int SLOTS          = 16;
  localparam int FILE_ID_BITS   = 8;
  localparam int BLOCK_NUM_BITS = 24;
  localparam int SLOT_BITS      = $clog2(SLOTS);
  localparam int OCC_BITS       = $clog2(SLOTS + 1);

  // field widths on the channels
  localparam int FILE_ID_W   = 8;
  localparam int BLOCK_NUM_W = 24;
  localparam int SLOT_W      = 4;

  // configuration port
  localparam int CAP_BITS   = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);
  localparam logic REG_CAPACITY = 1'b0;

  // action codes
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef logic [SLOTS-1:0]          slot_vec_t;
  typedef logic [SLOT_BITS-1:0]      slot_idx_t;
  typedef logic [OCC_BITS-1:0]       occ_t;
  typedef logic [FILE_ID_BITS-1:0]   tag_file_t;
  typedef logic [BLOCK_NUM_BITS-1:0] tag_block_t;

  typedef struct packed {
    logic lookup;       // access accepted: compare tags, pick victim and free slot
    logic flush_start;  // flush accepted: load the walk counter
    logic update;       // apply access result and emit it
    logic flush_step;   // evict the oldest remaining entry and emit it
  } lbp_cmd_t;

  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic flush_last;   // current flush step is the final one
  } lbp_status_t;

  // lowest set index of a slot vector, zero when none is set
  function automatic slot_idx_t first_set(slot_vec_t v);
    slot_idx_t idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_BITS'(i);
    end
    return idx;
  endfunction

endpackage

>>> src/lbp_in_if.sv
// lbp_in_if: request channel of the lru buffer pool (valid/ready plus request fields)
// depends on lbp_pkg
interface lbp_in_if import lbp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [FILE_ID_W-1:0]   file_id;
  logic [BLOCK_NUM_W-1:0] blk_num;

  modport source (output valid, action, file_id, blk_num, input ready);
  modport sink   (input valid, action, file_id, blk_num, output ready);
endinterface

>>> src/lbp_out_if.sv
// lbp_out_if: result channel of the lru buffer pool (valid/ready plus result fields)
// depends on lbp_pkg
interface lbp_out_if import lbp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [SLOT_W-1:0]      slot;
  logic                   load_needed;
  logic                   evict_valid;
  logic [FILE_ID_W-1:0]   evict_file_id;
  logic [BLOCK_NUM_W-1:0] evict_blk_num;
  logic                   last;

  modport source (output valid, hit, slot, load_needed, evict_valid, evict_file_id,
                  evict_blk_num, last, input ready);
  modport sink   (input valid, hit, slot, load_needed, evict_valid, evict_file_id,
                  evict_blk_num, last, output ready);
endinterface

>>> src/lbp_ctrl.sv
// lbp_ctrl: controller state machine of the lru buffer pool
// depends on lbp_pkg; drives lbp_dpath through lbp_cmd_t, reads lbp_status_t
module lbp_ctrl import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_action,
  output logic        in_ready,
  input  lbp_status_t status,
  output lbp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_UPD   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_FLUSH) begin
            cmd.flush_start = 1'b1;
            state_nxt       = ST_FLUSH;
          end else begin
            cmd.lookup = 1'b1;
            state_nxt  = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush_step = 1'b1;
          if (status.flush_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/lbp_dpath.sv
// lbp_dpath: tag store with associative compare, recency ranks, occupancy and result register
// depends on lbp_pkg; commanded by lbp_ctrl
module lbp_dpath import lbp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lbp_cmd_t               cmd,
  output lbp_status_t            status,
  input  occ_t                   eff_cap,
  input  logic [FILE_ID_W-1:0]   in_file_id,
  input  logic [BLOCK_NUM_W-1:0] in_blk_num,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_hit,
  output logic [SLOT_W-1:0]      out_slot,
  output logic                   out_load_needed,
  output logic                   out_evict_valid,
  output logic [FILE_ID_W-1:0]   out_evict_file_id,
  output logic [BLOCK_NUM_W-1:0] out_evict_blk_num,
  output logic                   out_last
);

  // entry state
  slot_vec_t  valid_r, valid_nxt;
  slot_idx_t  rank_r [SLOTS];
  slot_idx_t  rank_nxt [SLOTS];
  tag_file_t  tagf_r [SLOTS];
  tag_block_t tagb_r [SLOTS];
  occ_t       occ_r, occ_nxt;
  occ_t       fcnt_r, fcnt_nxt;

  // lookup results
  tag_file_t  req_f_r;
  tag_block_t req_b_r;
  logic       hit_r;
  slot_idx_t  hit_slot_r;
  slot_idx_t  hit_rank_r;
  logic       evict_r;
  slot_idx_t  vict_slot_r;
  slot_idx_t  free_slot_r;
  tag_file_t  evf_r;
  tag_block_t evb_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       o_hit_r, o_load_r, o_ev_r, o_last_r;
  slot_idx_t  o_slot_r;
  tag_file_t  o_evf_r;
  tag_block_t o_evb_r;

  tag_file_t  req_f;
  tag_block_t req_b;
  slot_vec_t  match_vec, old_vec, fl_vec;
  slot_idx_t  old_rank, fl_rank, match_slot, old_slot, fl_slot, ins_slot;
  logic       fl_found, out_load;

  assign req_f    = in_file_id[FILE_ID_BITS-1:0];
  assign req_b    = in_blk_num[BLOCK_NUM_BITS-1:0];
  assign old_rank = SLOT_BITS'(occ_r - 1'b1);
  assign fl_rank  = SLOT_BITS'(fcnt_r - 1'b1);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = valid_r[i] && (tagf_r[i] == req_f) && (tagb_r[i] == req_b);
      old_vec[i]   = valid_r[i] && (rank_r[i] == old_rank);
      fl_vec[i]    = valid_r[i] && (rank_r[i] == fl_rank);
    end
  end

  assign match_slot = first_set(match_vec);
  assign old_slot   = first_set(old_vec);
  assign fl_slot    = first_set(fl_vec);
  assign fl_found   = (|fl_vec) && (fcnt_r != '0);
  assign ins_slot   = evict_r ? vict_slot_r : free_slot_r;

  assign status.out_free   = !out_valid_r || out_ready;
  assign status.flush_last = (fcnt_r <= occ_t'(1));

  // next entry state
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    fcnt_nxt  = fcnt_r;
    if (cmd.flush_start) fcnt_nxt = occ_r;
    if (cmd.update) begin
      if (hit_r) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_r[i] && (rank_r[i] < hit_rank_r)) rank_nxt[i] = rank_r[i] + 1'b1;
        end
        rank_nxt[hit_slot_r] = '0;
      end else begin
        // victim leaves, all others age, new tag enters as most recent
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_r[i] && !(evict_r && (SLOT_BITS'(i) == ins_slot))) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        rank_nxt[ins_slot]  = '0;
        valid_nxt[ins_slot] = 1'b1;
        if (!evict_r) occ_nxt = occ_r + 1'b1;
      end
    end
    if (cmd.flush_step) begin
      if (fcnt_r != '0) fcnt_nxt = fcnt_r - 1'b1;
      if (fl_found) begin
        valid_nxt[fl_slot] = 1'b0;
        rank_nxt[fl_slot]  = '0;
      end
      if (status.flush_last) occ_nxt = '0;
    end
  end

  assign out_load      = cmd.update || (cmd.flush_step && ((fcnt_r == '0) || fl_found));
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) rank_r[i] <= '0;
    end else begin
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
      rank_r      <= rank_nxt;
    end
  end

  // payload: tags, lookup results, result fields
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      req_f_r     <= req_f;
      req_b_r     <= req_b;
      hit_r       <= |match_vec;
      hit_slot_r  <= match_slot;
      hit_rank_r  <= rank_r[match_slot];
      evict_r     <= (occ_r >= eff_cap) && (occ_r != '0) && (|old_vec);
      vict_slot_r <= old_slot;
      free_slot_r <= first_set(~valid_r);
      evf_r       <= tagf_r[old_slot];
      evb_r       <= tagb_r[old_slot];
    end
    if (cmd.update && !hit_r) begin
      tagf_r[ins_slot] <= req_f_r;
      tagb_r[ins_slot] <= req_b_r;
    end
    if (cmd.update) begin
      o_last_r <= 1'b1;
      if (hit_r) begin
        o_hit_r  <= 1'b1;
        o_slot_r <= hit_slot_r;
        o_load_r <= 1'b0;
        o_ev_r   <= 1'b0;
        o_evf_r  <= '0;
        o_evb_r  <= '0;
      end else begin
        o_hit_r  <= 1'b0;
        o_slot_r <= ins_slot;
        o_load_r <= 1'b1;
        o_ev_r   <= evict_r;
        o_evf_r  <= evict_r ? evf_r : '0;
        o_evb_r  <= evict_r ? evb_r : '0;
      end
    end else if (cmd.flush_step) begin
      o_hit_r  <= 1'b0;
      o_load_r <= 1'b0;
      if (fcnt_r == '0) begin
        // empty pool
        o_slot_r <= '0;
        o_ev_r   <= 1'b0;
        o_evf_r  <= '0;
        o_evb_r  <= '0;
        o_last_r <= 1'b1;
      end else begin
        o_slot_r <= fl_slot;
        o_ev_r   <= 1'b1;
        o_evf_r  <= tagf_r[fl_slot];
        o_evb_r  <= tagb_r[fl_slot];
        o_last_r <= (fcnt_r == occ_t'(1));
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = o_hit_r;
  assign out_slot          = SLOT_W'(o_slot_r);
  assign out_load_needed   = o_load_r;
  assign out_evict_valid   = o_ev_r;
  assign out_evict_file_id = FILE_ID_W'(o_evf_r);
  assign out_evict_blk_num = BLOCK_NUM_W'(o_evb_r);
  assign out_last          = o_last_r;

endmodule

>>> src/lru_block_buffer_pool_unit.sv
// lru_block_buffer_pool_unit: access compares tags at the accept edge; rank update and
// result load follow in the update state once the result register frees, then the next
// access is accepted; flush evicts one entry per step through the rank search (one empty
// result if empty); a stalled output holds the controller until the result register frees
// reset (rst_n low, synchronous) clears entry valid bits, ranks, occupancy, capacity to 16
// depends on lbp_pkg, lbp_in_if, lbp_out_if, lbp_ctrl, lbp_dpath
module lru_block_buffer_pool_unit import lbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lbp_in_if.sink                in_chan,
  lbp_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // capacity register, written in the apb access phase
  logic [CAP_BITS-1:0] cap_r;
  logic                cfg_wr;
  occ_t                eff_cap;

  lbp_cmd_t    cmd;
  lbp_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_BITS-1:0];
    end
  end

  // register readback, unused index reads zero
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(cap_r) : '0;

  // capacity clamped into 1..slots
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = occ_t'(1);
    end else if (32'(cap_r) > SLOTS) begin
      eff_cap = occ_t'(SLOTS);
    end else begin
      eff_cap = occ_t'(cap_r);
    end
  end

  // sequencer: idle / update / flush walk
  lbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // tags, ranks, occupancy and the result register
  lbp_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .eff_cap           (eff_cap),
    .in_file_id        (in_chan.file_id),
    .in_blk_num        (in_chan.blk_num),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_hit           (out_chan.hit),
    .out_slot          (out_chan.slot),
    .out_load_needed   (out_chan.load_needed),
    .out_evict_valid   (out_chan.evict_valid),
    .out_evict_file_id (out_chan.evict_file_id),
    .out_evict_blk_num (out_chan.evict_blk_num),
    .out_last          (out_chan.last)
  );

  // at most one emitting command per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.update && cmd.flush_step))
    else $error("update and flush step together");

  // a result is loaded only when the result register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update || cmd.flush_step) |-> status.out_free)
    else $error("result loaded over a pending result");

  // no transfer in while an item is still being worked
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> !(cmd.update || cmd.flush_step))
    else $error("input taken while busy");

  // an accepted access occupies the following cycle
  a_access_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.action == ACT_ACCESS)) |=> !in_chan.ready)
    else $error("ready right after an access");

endmodule
